FILE: hw/rtl/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, codes and helpers of the clipped bitmap glyph renderer.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // field widths
  localparam int CODE_W    = 8;
  localparam int ROW_W     = 4;
  localparam int ADDR_W    = CODE_W + ROW_W;
  localparam int MASK_W    = 16;
  localparam int SIZE_W    = 5;
  localparam int COORD_W   = 16;
  localparam int VIEW_W    = 15;
  localparam int PEN_W     = 18;
  localparam int COLOR_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // glyph size limit and coordinate limits
  localparam logic [SIZE_W-1:0]      GLYPH_SIZE_CAP = 5'd16;
  localparam logic signed [PEN_W-1:0] PEN_MAX   = 18'sh1FFFF;
  localparam logic signed [16:0]      SCREEN_END = 17'sh08000;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_GLYPH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd5;

  // per-character clip setup handed from the setup unit to the sequencer
  typedef struct packed {
    logic              visible;
    logic [MASK_W-1:0] col_mask;
    logic [SIZE_W-1:0] row_lo;
    logic [SIZE_W-1:0] row_hi;
    logic [PEN_W-1:0]  pen_next;
  } gbr_setup_t;

  // clamp a signed distance into 0..16
  function automatic logic [SIZE_W-1:0] clamp16(input logic signed [18:0] v);
    logic [SIZE_W-1:0] res;
    if (v < 19'sd0) begin
      res = '0;
    end else if (v > 19'sd16) begin
      res = GLYPH_SIZE_CAP;
    end else begin
      res = v[SIZE_W-1:0];
    end
    return res;
  endfunction

  // glyph size register into 1..16
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = 5'd1;
    end else if (v > GLYPH_SIZE_CAP) begin
      res = GLYPH_SIZE_CAP;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/gbr_glyph_store.sv
// ----------------------------------------------------------------------------
// gbr_glyph_store
// Glyph row memory: one 16-bit pixel row per character and row index,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbr_glyph_store
  import gbr_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [MASK_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [MASK_W-1:0] rd_data
);

  logic [MASK_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/gbr_char_setup.sv
// ----------------------------------------------------------------------------
// gbr_char_setup
// Per-character clip setup: visible column mask, visible row span and the
// saturated pen position after the advance.
// ----------------------------------------------------------------------------
module gbr_char_setup
  import gbr_pkg::*;
(
  input  logic signed [COORD_W-1:0] view_left,
  input  logic signed [COORD_W-1:0] view_top,
  input  logic [VIEW_W-1:0]         view_width,
  input  logic [VIEW_W-1:0]         view_height,
  input  logic [SIZE_W-1:0]         glyph_width,
  input  logic [SIZE_W-1:0]         glyph_height,
  input  logic signed [PEN_W-1:0]   pen_x,
  input  logic signed [COORD_W-1:0] pen_y,
  output gbr_setup_t                setup
);

  logic [SIZE_W-1:0]  w;
  logic [SIZE_W-1:0]  h;
  logic signed [16:0] right_raw;
  logic signed [16:0] bottom_raw;
  logic signed [16:0] right_c;
  logic signed [16:0] bottom_c;
  logic signed [18:0] lo_d;
  logic signed [18:0] hi_d;
  logic signed [18:0] top_d;
  logic signed [18:0] bot_d;
  logic signed [18:0] pen_sum;
  logic [SIZE_W-1:0]  lo_c;
  logic [SIZE_W-1:0]  hi_c;
  logic [SIZE_W-1:0]  rlo;
  logic [SIZE_W-1:0]  rhi_c;
  logic [SIZE_W-1:0]  rhi;
  logic               hit;
  logic [MASK_W-1:0]  col_mask;

  // window edges, right and bottom limited to the screen end
  always_comb begin
    w          = clamp_size(glyph_width);
    h          = clamp_size(glyph_height);
    right_raw  = 17'(view_left) + $signed({2'b00, view_width});
    bottom_raw = 17'(view_top) + $signed({2'b00, view_height});
    right_c    = (right_raw > SCREEN_END) ? SCREEN_END : right_raw;
    bottom_c   = (bottom_raw > SCREEN_END) ? SCREEN_END : bottom_raw;
  end

  // distances from pen to window edges, clamped to the glyph cell
  always_comb begin
    lo_d  = 19'(view_left) - 19'(pen_x);
    hi_d  = 19'(right_c) - 19'(pen_x);
    top_d = 19'(view_top) - 19'(pen_y);
    bot_d = 19'(bottom_c) - 19'(pen_y);
    lo_c  = clamp16(lo_d);
    hi_c  = clamp16(hi_d);
    rlo   = clamp16(top_d);
    rhi_c = clamp16(bot_d);
    rhi   = (rhi_c < h) ? rhi_c : h;
    hit   = (lo_c < w) && (hi_c != '0);
  end

  // column mask, one independent compare pair per pixel
  always_comb begin
    for (int b = 0; b < MASK_W; b++) begin
      col_mask[b] = (SIZE_W'(b) >= lo_c) && (SIZE_W'(b) < hi_c) && (SIZE_W'(b) < w);
    end
  end

  // pen advance with saturation
  always_comb begin
    pen_sum        = 19'(pen_x) + $signed({14'b0, w});
    setup.pen_next = (pen_sum > 19'(PEN_MAX)) ? PEN_MAX : pen_sum[PEN_W-1:0];
    setup.col_mask = col_mask;
    setup.row_lo   = rlo;
    setup.row_hi   = rhi;
    setup.visible  = hit && (rlo < rhi);
  end

endmodule

FILE: hw/rtl/clipped_bitmap_glyph_renderer.sv
// ----------------------------------------------------------------------------
// clipped_bitmap_glyph_renderer
// Fixed-size bitmap font renderer with a rectangular clip window.
// ----------------------------------------------------------------------------
// String starts and glyph row writes complete when accepted. A draw request
// passes an accept step and a clip setup step that also issues the first
// glyph store read, then gives one row beat per cycle while the output is
// not stalled for each of the n glyph rows that fall inside the window
// (0 to 16), paced by the single read port of the glyph store. Only one
// item is in work at a time; the output register lets a new item be taken
// while the last row beat still waits. The glyph store is not cleared at
// reset: a glyph row must be written before any character that uses it is
// drawn. Configuration takes effect from the next draw request.
// ----------------------------------------------------------------------------
module clipped_bitmap_glyph_renderer
  import gbr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [CODE_W-1:0]         in_char_code,
  input  logic [ROW_W-1:0]          in_glyph_row,
  input  logic [MASK_W-1:0]         in_row_bits,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic [COLOR_W-1:0]        in_ink_color,
  // row result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_row_x,
  output logic signed [COORD_W-1:0] out_row_y,
  output logic [MASK_W-1:0]         out_pixel_mask,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_last_row
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;

  // configuration registers
  logic signed [COORD_W-1:0] view_left_r;
  logic signed [COORD_W-1:0] view_top_r;
  logic [VIEW_W-1:0]         view_width_r;
  logic [VIEW_W-1:0]         view_height_r;
  logic [SIZE_W-1:0]         glyph_width_r;
  logic [SIZE_W-1:0]         glyph_height_r;

  // string state
  logic signed [PEN_W-1:0]   pen_x_r;
  logic signed [COORD_W-1:0] pen_y_r;
  logic [COLOR_W-1:0]        color_r;

  // sequencer
  logic [1:0]                state_r;
  logic [1:0]                state_nxt;
  logic [CODE_W-1:0]         code_r;
  logic [ROW_W-1:0]          r_cur_r;
  logic [SIZE_W-1:0]         row_hi_r;
  logic [MASK_W-1:0]         col_mask_r;
  logic [COORD_W-1:0]        x_lat_r;

  // output register
  logic                      out_valid_r;
  logic [COORD_W-1:0]        out_row_x_r;
  logic [COORD_W-1:0]        out_row_y_r;
  logic [MASK_W-1:0]         out_mask_r;
  logic [COLOR_W-1:0]        out_color_r;
  logic                      out_last_r;

  logic                      in_acc;
  logic                      gs_we;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [MASK_W-1:0]         rd_data;
  logic                      row_load;
  logic                      row_last;
  gbr_setup_t                setup;

  // request handshake, one item at a time
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign gs_we    = in_acc && (in_req_type == REQ_GLYPH);
  assign row_last = (({1'b0, r_cur_r} + 5'd1) == row_hi_r);

  // glyph row memory, written only while idle so reads never overlap writes
  gbr_glyph_store u_store (
    .clk     (clk),
    .wr_en   (gs_we),
    .wr_addr ({in_char_code, in_glyph_row}),
    .wr_data (in_row_bits),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // clip setup from the current pen and window
  gbr_char_setup u_setup (
    .view_left    (view_left_r),
    .view_top     (view_top_r),
    .view_width   (view_width_r),
    .view_height  (view_height_r),
    .glyph_width  (glyph_width_r),
    .glyph_height (glyph_height_r),
    .pen_x        (pen_x_r),
    .pen_y        (pen_y_r),
    .setup        (setup)
  );

  // sequencer next state and glyph store reads
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = {code_r, setup.row_lo[ROW_W-1:0]};
    row_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type == REQ_DRAW)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (setup.visible) begin
          rd_en     = 1'b1;
          state_nxt = ST_ROW;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROW: begin
        if (!out_valid_r || !out_stall) begin
          row_load = 1'b1;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {code_r, r_cur_r + 4'd1};
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      view_left_r    <= '0;
      view_top_r     <= '0;
      view_width_r   <= 15'd640;
      view_height_r  <= 15'd480;
      glyph_width_r  <= 5'd8;
      glyph_height_r <= 5'd8;
      pen_x_r        <= '0;
      pen_y_r        <= '0;
      color_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIEW_LEFT:    view_left_r    <= cfg_data;
          CFG_VIEW_TOP:     view_top_r     <= cfg_data;
          CFG_VIEW_WIDTH:   view_width_r   <= cfg_data[VIEW_W-1:0];
          CFG_VIEW_HEIGHT:  view_height_r  <= cfg_data[VIEW_W-1:0];
          CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[SIZE_W-1:0];
          CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && (in_req_type == REQ_START)) begin
        pen_x_r <= PEN_W'(in_start_x);
        pen_y_r <= in_start_y;
        color_r <= in_ink_color;
      end
      // pen advances once per drawn character
      if (state_r == ST_SETUP) begin
        pen_x_r <= setup.pen_next;
      end
      if (row_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-character and per-row payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_char_code;
    end
    if (state_r == ST_SETUP) begin
      r_cur_r    <= setup.row_lo[ROW_W-1:0];
      row_hi_r   <= setup.row_hi;
      col_mask_r <= setup.col_mask;
      x_lat_r    <= pen_x_r[COORD_W-1:0];
    end else if (row_load) begin
      r_cur_r <= r_cur_r + 4'd1;
    end
    if (row_load) begin
      out_row_x_r <= x_lat_r;
      out_row_y_r <= pen_y_r + {{(COORD_W-ROW_W){1'b0}}, r_cur_r};
      out_mask_r  <= rd_data & col_mask_r;
      out_color_r <= color_r;
      out_last_r  <= row_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_x       = out_row_x_r;
  assign out_row_y       = out_row_y_r;
  assign out_pixel_mask  = out_mask_r;
  assign out_pixel_color = out_color_r;
  assign out_last_row    = out_last_r;

  // row walk stays inside the visible span
  a_row_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> ({1'b0, r_cur_r} < row_hi_r))
    else $error("row index past visible span");

  // glyph writes never collide with a character in work
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    gs_we |-> (state_r == ST_IDLE) && !rd_en)
    else $error("glyph write while drawing");

  // the last row beat ends the character
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (row_load && row_last) |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("character did not end after last row");

  // setup lasts a single cycle
  a_setup_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |=> (state_r != ST_SETUP))
    else $error("setup repeated");

endmodule

FILE: tb/clipped_bitmap_glyph_renderer_checker.sv
// ----------------------------------------------------------------------------
// clipped_bitmap_glyph_renderer_checker
// Watches the config port and both channels of the glyph renderer, keeps its
// own glyph store, pen and clip window, predicts every row beat of each drawn
// character and compares the beats that come out against that prediction.
// ----------------------------------------------------------------------------
module clipped_bitmap_glyph_renderer_checker
  import gbr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [CODE_W-1:0]         in_char_code,
  input  logic [ROW_W-1:0]          in_glyph_row,
  input  logic [MASK_W-1:0]         in_row_bits,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic [COLOR_W-1:0]        in_ink_color,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_row_x,
  input  logic signed [COORD_W-1:0] out_row_y,
  input  logic [MASK_W-1:0]         out_pixel_mask,
  input  logic [COLOR_W-1:0]        out_pixel_color,
  input  logic                      out_last_row,
  output int                        rows_pending,
  output int                        mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_W-1:0] row_x;
    logic signed [COORD_W-1:0] row_y;
    logic [MASK_W-1:0]         pixel_mask;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last_row;
  } row_beat_t;

  // mirrored block state
  logic [MASK_W-1:0]         glyph_rows [0:(1<<ADDR_W)-1];
  logic signed [PEN_W-1:0]   pen_x;
  logic signed [COORD_W-1:0] pen_y;
  logic [COLOR_W-1:0]        ink;

  // mirrored clip window and glyph size
  logic signed [COORD_W-1:0] view_left;
  logic signed [COORD_W-1:0] view_top;
  logic [VIEW_W-1:0]         view_width;
  logic [VIEW_W-1:0]         view_height;
  logic [SIZE_W-1:0]         glyph_width;
  logic [SIZE_W-1:0]         glyph_height;

  row_beat_t expected_rows [$];
  int        misses;

  // rows of one character inside the window, then the pen advance
  task automatic render_char(input logic [CODE_W-1:0] code);
    int          gw, gh, x, left, right, top, bottom, yy, nrows, r, b, i;
    logic [15:0] bits, mask;
    row_beat_t   beats [16];
    gw = (glyph_width == '0) ? 1 : ((glyph_width > 5'd16) ? 16 : int'(glyph_width));
    gh = (glyph_height == '0) ? 1 : ((glyph_height > 5'd16) ? 16 : int'(glyph_height));
    x      = int'(pen_x);
    left   = int'(view_left);
    right  = left + int'(view_width);
    top    = int'(view_top);
    bottom = top + int'(view_height);
    if (right > 32768) right = 32768;
    if (bottom > 32768) bottom = 32768;
    nrows = 0;
    if (x + gw > left && x < right) begin
      for (r = 0; r < gh; r++) begin
        yy = int'(pen_y) + r;
        if (yy >= top && yy < bottom) begin
          bits = glyph_rows[{code, r[3:0]}];
          mask = '0;
          for (b = 0; b < gw; b++) begin
            if (bits[b] && x + b >= left && x + b < right) mask[b] = 1'b1;
          end
          beats[nrows].row_x       = x[15:0];
          beats[nrows].row_y       = yy[15:0];
          beats[nrows].pixel_mask  = mask;
          beats[nrows].pixel_color = ink;
          beats[nrows].last_row    = 1'b0;
          nrows++;
        end
      end
    end
    for (i = 0; i < nrows; i++) begin
      beats[i].last_row = (i == nrows - 1);
      expected_rows.push_back(beats[i]);
    end
    // pen saturates at the top of its 18-bit range
    if (x > 131071 - gw) pen_x = 18'sh1FFFF;
    else pen_x = PEN_W'(x + gw);
  endtask

  always @(posedge clk) begin : watch
    row_beat_t got, want;
    if (!rst_n) begin
      pen_x        = '0;
      pen_y        = '0;
      ink          = '0;
      view_left    = '0;
      view_top     = '0;
      view_width   = 15'd640;
      view_height  = 15'd480;
      glyph_width  = 5'd8;
      glyph_height = 5'd8;
      misses       = 0;
      expected_rows.delete();
      rows_pending   <= 0;
      mismatch_count <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIEW_LEFT:    view_left    = cfg_data;
          CFG_VIEW_TOP:     view_top     = cfg_data;
          CFG_VIEW_WIDTH:   view_width   = cfg_data[VIEW_W-1:0];
          CFG_VIEW_HEIGHT:  view_height  = cfg_data[VIEW_W-1:0];
          CFG_GLYPH_WIDTH:  glyph_width  = cfg_data[SIZE_W-1:0];
          CFG_GLYPH_HEIGHT: glyph_height = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      // request beat
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_START: begin
            pen_x = in_start_x;
            pen_y = in_start_y;
            ink   = in_ink_color;
          end
          REQ_GLYPH: glyph_rows[{in_char_code, in_glyph_row}] = in_row_bits;
          REQ_DRAW:  render_char(in_char_code);
          default: ;
        endcase
      end

      // row beat against the oldest prediction
      if (out_valid && !out_stall) begin
        got.row_x       = out_row_x;
        got.row_y       = out_row_y;
        got.pixel_mask  = out_pixel_mask;
        got.pixel_color = out_pixel_color;
        got.last_row    = out_last_row;
        if (expected_rows.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("%0t: unexpected row beat x=%0d y=%0d mask=%h color=%h last=%b",
                     $realtime, got.row_x, got.row_y, got.pixel_mask, got.pixel_color,
                     got.last_row);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            misses++;
            if (misses <= 10) begin
              $display("%0t: row beat mismatch", $realtime);
              $display("  exp x=%0d y=%0d mask=%h color=%h last=%b",
                       want.row_x, want.row_y, want.pixel_mask, want.pixel_color,
                       want.last_row);
              $display("  got x=%0d y=%0d mask=%h color=%h last=%b",
                       got.row_x, got.row_y, got.pixel_mask, got.pixel_color,
                       got.last_row);
            end
          end
        end
      end

      rows_pending   <= expected_rows.size();
      mismatch_count <= misses;
    end
  end

endmodule

FILE: tb/clipped_bitmap_glyph_renderer_tb.sv
// ----------------------------------------------------------------------------
// clipped_bitmap_glyph_renderer_tb
// Drives glyph row writes, string starts and character draws into the glyph
// renderer under several clip windows and glyph sizes, with random gaps and
// output stalls; the checker beside the block predicts and compares rows.
// ----------------------------------------------------------------------------
module clipped_bitmap_glyph_renderer_tb
  import gbr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HANG_LIMIT   = 4000;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 16;
  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_req_type;
  logic [CODE_W-1:0]         in_char_code;
  logic [ROW_W-1:0]          in_glyph_row;
  logic [MASK_W-1:0]         in_row_bits;
  logic signed [COORD_W-1:0] in_start_x;
  logic signed [COORD_W-1:0] in_start_y;
  logic [COLOR_W-1:0]        in_ink_color;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_row_x;
  logic signed [COORD_W-1:0] out_row_y;
  logic [MASK_W-1:0]         out_pixel_mask;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic                      out_last_row;
  int                        rows_pending;
  int                        mismatch_count;

  // stimulus-side view of the window, used to aim the pen and to pick the glyph rows to write
  int win_left, win_top, win_w, win_h, cur_w, cur_h;
  logic [15:0] rows_done [256] = '{default: '0};
  logic [7:0]  fav_codes [8] = '{8'h00, 8'h01, 8'h20, 8'h41, 8'h7F, 8'h80, 8'hA5, 8'hFF};

  bit no_idle = 1'b0;
  int items_sent = 0, draws_sent = 0, walk_draws = 0, cfg_writes = 0, rows_seen = 0;
  int stuck_cycles = 0, stall_left = 0, run_left = 0;

  clipped_bitmap_glyph_renderer dut (.*);
  clipped_bitmap_glyph_renderer_checker checker_i (.*);

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] sat16(input int v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7FFF;
    return v[15:0];
  endfunction

  // pen x near the left or right window edge, sometimes anywhere
  function automatic logic signed [15:0] pick_x();
    int r, right, x;
    right = win_left + win_w;
    if (right > 32768) right = 32768;
    r = $urandom_range(0, 9);
    if (r < 5) x = win_left - cur_w - 2 + int'($urandom_range(0, 40 + cur_w));
    else if (r < 8) x = right - int'($urandom_range(0, 3 * cur_w + 4));
    else x = int'($urandom_range(0, 65535)) - 32768;
    return sat16(x);
  endfunction

  // pen y near the top or bottom window edge, sometimes anywhere
  function automatic logic signed [15:0] pick_y();
    int r, bottom, y;
    bottom = win_top + win_h;
    if (bottom > 32768) bottom = 32768;
    r = $urandom_range(0, 9);
    if (r < 5) y = win_top - cur_h - 2 + int'($urandom_range(0, 20 + cur_h));
    else if (r < 8) y = bottom - int'($urandom_range(0, cur_h + 4));
    else y = int'($urandom_range(0, 65535)) - 32768;
    return sat16(y);
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) < 3) return 8'($urandom);
    return fav_codes[$urandom_range(0, 7)];
  endfunction

  function automatic logic [15:0] pick_bits();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // one request beat: optional gap, then hold until accepted
  task automatic send_item(input logic [1:0] req, input logic [7:0] code,
                           input logic [3:0] row, input logic [15:0] bits,
                           input logic signed [15:0] sx, input logic signed [15:0] sy,
                           input logic [31:0] ink);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_code <= code;
    in_glyph_row <= row;
    in_row_bits  <= bits;
    in_start_x   <= sx;
    in_start_y   <= sy;
    in_ink_color <= ink;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic send_start(input logic signed [15:0] sx, input logic signed [15:0] sy,
                            input logic [31:0] ink);
    send_item(REQ_START, 8'($urandom), 4'($urandom), 16'($urandom), sx, sy, ink);
  endtask

  task automatic send_draw(input logic [7:0] code);
    send_item(REQ_DRAW, code, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              $urandom);
    draws_sent++;
  endtask

  task automatic send_glyph(input logic [7:0] code, input logic [3:0] row,
                            input logic [15:0] bits);
    send_item(REQ_GLYPH, code, row, bits, 16'($urandom), 16'($urandom), $urandom);
    rows_done[code][row] = 1'b1;
  endtask

  // write every glyph row the current height reaches that is still missing
  task automatic fill_glyph(input logic [7:0] code);
    int r;
    for (r = 0; r < cur_h; r++) begin
      if (!rows_done[code][r]) send_glyph(code, r[3:0], pick_bits());
    end
  endtask

  // sender holds off until every predicted row has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  // drained plus slack for a draw that makes no rows
  task automatic wait_idle();
    drain();
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_view(input logic [15:0] left, input logic [15:0] top,
                          input logic [15:0] width, input logic [15:0] height,
                          input logic [4:0] gwd, input logic [4:0] ghd);
    cfg_write(CFG_VIEW_LEFT, left);
    cfg_write(CFG_VIEW_TOP, top);
    cfg_write(CFG_VIEW_WIDTH, width);
    cfg_write(CFG_VIEW_HEIGHT, height);
    cfg_write(CFG_GLYPH_WIDTH, {11'($urandom), gwd});
    cfg_write(CFG_GLYPH_HEIGHT, {11'($urandom), ghd});
    cfg_we   <= 1'b0;
    win_left = int'(signed'(left));
    win_top  = int'(signed'(top));
    win_w    = int'(width[14:0]);
    win_h    = int'(height[14:0]);
    cur_w    = (gwd == 5'd0) ? 1 : ((gwd > 5'd16) ? 16 : int'(gwd));
    cur_h    = (ghd == 5'd0) ? 1 : ((ghd > 5'd16) ? 16 : int'(ghd));
  endtask

  // glyph writes, a string start and a run of characters
  task automatic run_string();
    int         n, i;
    logic [7:0] codes [6];
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      codes[i] = pick_code();
      fill_glyph(codes[i]);
    end
    send_start(pick_x(), pick_y(), $urandom);
    for (i = 0; i < n; i++) send_draw(codes[i]);
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  // lone or ignored requests
  task automatic noise();
    logic [7:0] code;
    case ($urandom_range(0, 3))
      0: send_glyph(8'($urandom), 4'($urandom), pick_bits());
      1: send_item(REQ_NONE, 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom);
      2: send_start(16'($urandom), 16'($urandom), $urandom);
      default: begin
        code = pick_code();
        fill_glyph(code);
        send_draw(code);
      end
    endcase
  endtask

  // output stall: bursts of free flow, gaps mostly short
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      run_left   <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left  <= run_left - 1;
    end else begin
      out_stall  <= 1'b0;
      run_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
      stall_left <= pick_gap();
    end
  end

  // hang watchdog and row beat count
  always @(posedge clk) begin
    if (out_valid && !out_stall) rows_seen <= rows_seen + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= HANG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d rows pending",
                 HANG_LIMIT, rows_pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int p, r, items_goal;
    logic [15:0] bits;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_req_type  = REQ_START;
    in_char_code = '0;
    in_glyph_row = '0;
    in_row_bits  = '0;
    in_start_x   = '0;
    in_start_y   = '0;
    in_ink_color = '0;
    win_left = 0;
    win_top  = 0;
    win_w    = 640;
    win_h    = 480;
    cur_w    = 8;
    cur_h    = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full glyph with extreme row patterns, then edge cases at reset window
    for (r = 0; r < 16; r++) begin
      case (r)
        0:       bits = 16'hFFFF;
        1:       bits = 16'h0000;
        2:       bits = 16'h8001;
        3:       bits = 16'h5555;
        4:       bits = 16'hAAAA;
        default: bits = 16'($urandom);
      endcase
      send_glyph(8'hFF, r[3:0], bits);
    end
    send_start(-16'sd4, -16'sd3, 32'hFFFF_FFFF);   // clipped at left and top
    send_draw(8'hFF);
    send_draw(8'hFF);
    send_start(16'sd636, 16'sd476, 32'h0000_0000); // clipped at right and bottom
    send_draw(8'hFF);
    send_start(-16'sd8, 16'sd10, $urandom);        // ends exactly at the left edge
    send_draw(8'hFF);
    send_draw(8'hFF);
    send_start(16'sd20, -16'sd8, $urandom);        // no row inside vertically
    send_draw(8'hFF);
    send_item(REQ_NONE, 8'hFF, 4'hF, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    send_start(16'sh8000, 16'sh7FFF, $urandom);    // far corners of the coordinate range
    send_draw(8'hFF);
    send_start(16'sh7FFF, 16'sh8000, $urandom);
    send_draw(8'hFF);

    // random strings under a series of windows and glyph sizes
    items_goal = items_sent;
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_view(16'd0, 16'd0, 16'd640, 16'd480, 5'd8, 5'd8);
        1: set_view(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 5'd16, 5'd16);
        2: set_view(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 5'd0, 5'd0);
        3: begin
          cfg_write(CFG_SPARE_A, 16'($urandom));
          cfg_write(CFG_SPARE_B, 16'($urandom));
          set_view(16'd10, 16'd5, 16'h0000, 16'h8000, 5'd31, 5'd31);
        end
        default: set_view(($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 100) - 50)
                                                      : 16'($urandom),
                          ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 100) - 50)
                                                      : 16'($urandom),
                          ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 150))
                                                     : 16'($urandom),
                          ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 150))
                                                     : 16'($urandom),
                          ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 16))
                                                      : 5'($urandom),
                          ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 16))
                                                      : 5'($urandom));
      endcase
      no_idle = (p == 5);
      items_goal = items_goal + PHASE_ITEMS;
      while (items_sent < items_goal) begin
        if ($urandom_range(0, 9) < 8) run_string();
        else noise();
      end
    end
    no_idle = 1'b0;

    // pen walks past the 16-bit range; only the first draws are visible
    wait_idle();
    set_view(16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 5'd15, 5'd1);
    send_start(16'sd32740, 16'sd3, $urandom);
    no_idle = 1'b1;
    repeat (8) begin
      send_draw(8'hFF);
      walk_draws++;
    end
    no_idle = 1'b0;
    send_start(16'sd5, 16'sd0, $urandom);
    send_draw(8'hFF);

    // drain and let the pipeline settle
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests (%0d draws), %0d register writes, %0d row beats",
             items_sent, draws_sent, cfg_writes, rows_seen);
    $display("pen walk past the 16-bit range used %0d draws", walk_draws);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
